FILE: rtl/lbcte_pkg.sv
// Shared types and constants of the cache tag engine.
`default_nettype none
package lbcte_pkg;

   // Width of the slot index reported on the result channel.
   localparam int SLOT_IDX_W = 6;

   // Operation codes of an input word.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_INVAL = 1'b1;

   // Result status codes.
   localparam logic [2:0] STATUS_HIT       = 3'd0;
   localparam logic [2:0] STATUS_FILLED    = 3'd1;
   localparam logic [2:0] STATUS_FILL_FAIL = 3'd2;
   localparam logic [2:0] STATUS_INVAL     = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic issue;
      logic update;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
   } ctrl_stat_type;

endpackage
`default_nettype wire

FILE: rtl/lbcte_ctrl.sv
// Controller state machine that sequences the tag scan and update.
`default_nettype none
module lbcte_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire lbcte_pkg::ctrl_stat_type stat,
   output lbcte_pkg::ctrl_cmd_type      cmd
);
   import lbcte_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      cmd.start  = 1'b0;
      cmd.issue  = 1'b0;
      cmd.update = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/lbcte_dp.sv
// Datapath: slot tag and stamp memories, scan trackers, counters and result registers.
`default_nettype none
module lbcte_dp #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lbcte_pkg::ctrl_cmd_type            cmd,
   output lbcte_pkg::ctrl_stat_type                stat,
   input  wire logic                               req_func,
   input  wire logic [63:0]                        req_sector_number,
   input  wire logic                               req_fill_failed,
   output logic [2:0]                              rsp_status,
   output logic [lbcte_pkg::SLOT_IDX_W-1:0]        rsp_slot_index,
   output logic                                    rsp_evicted,
   output logic [63:0]                             rsp_hit_total,
   output logic [63:0]                             rsp_miss_total,
   output logic [63:0]                             rsp_eviction_total
);
   import lbcte_pkg::*;

   localparam int IW = $clog2(NUM_SLOTS);

   // Slot storage. Sector and stamp are read for every slot but only matter for
   // valid slots, and a slot becomes valid only by a fill that writes both.
   logic [63:0]          sector_mem [NUM_SLOTS];
   logic [63:0]          stamp_mem  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [NUM_SLOTS-1:0] valid_in;

   // Latched request word.
   logic        func_ff;
   logic [63:0] sector_ff;
   logic        fail_ff;

   // Scan pipeline and trackers.
   logic [IW-1:0] scan_idx_ff;
   logic          pend_ff;
   logic [IW-1:0] eval_idx_ff;
   logic [63:0]   rd_sector_ff;
   logic [63:0]   rd_stamp_ff;
   logic          hit_found_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          inv_found_ff;
   logic [IW-1:0] inv_idx_ff;
   logic [63:0]   min_stamp_ff;
   logic [IW-1:0] min_idx_ff;

   // Counters.
   logic [63:0] clock_ff;
   logic [63:0] hit_cnt_ff;
   logic [63:0] miss_cnt_ff;
   logic [63:0] evict_cnt_ff;
   logic [63:0] clock_in;
   logic [63:0] hit_cnt_in;
   logic [63:0] miss_cnt_in;
   logic [63:0] evict_cnt_in;

   // Result registers.
   logic [2:0]            status_ff;
   logic [2:0]            status_in;
   logic [SLOT_IDX_W-1:0] slot_idx_ff;
   logic [IW-1:0]         slot_idx_in;
   logic                  evicted_ff;
   logic                  evicted_in;

   // Update controls.
   logic [IW-1:0] victim_idx;
   logic          sector_we;
   logic          stamp_we;
   logic [IW-1:0] wr_idx;
   logic          eval_vld;

   assign stat.scan_last = (scan_idx_ff == IW'(NUM_SLOTS - 1));
   assign eval_vld       = valid_ff[eval_idx_ff];

   // Commit decision once the scan has finished.
   always_comb begin
      victim_idx   = inv_found_ff ? inv_idx_ff : min_idx_ff;
      valid_in     = valid_ff;
      clock_in     = clock_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      status_in    = STATUS_NOT_FOUND;
      slot_idx_in  = '0;
      evicted_in   = 1'b0;
      sector_we    = 1'b0;
      stamp_we     = 1'b0;
      wr_idx       = victim_idx;
      if (func_ff == FUNC_READ) begin
         if (hit_found_ff) begin
            clock_in    = clock_ff + 64'd1;
            hit_cnt_in  = hit_cnt_ff + 64'd1;
            status_in   = STATUS_HIT;
            slot_idx_in = hit_idx_ff;
            stamp_we    = 1'b1;
            wr_idx      = hit_idx_ff;
         end else begin
            slot_idx_in = victim_idx;
            evicted_in  = !inv_found_ff;
            if (!inv_found_ff) evict_cnt_in = evict_cnt_ff + 64'd1;
            if (fail_ff) begin
               valid_in[victim_idx] = 1'b0;
               status_in            = STATUS_FILL_FAIL;
            end else begin
               valid_in[victim_idx] = 1'b1;
               clock_in             = clock_ff + 64'd1;
               miss_cnt_in          = miss_cnt_ff + 64'd1;
               status_in            = STATUS_FILLED;
               sector_we            = 1'b1;
               stamp_we             = 1'b1;
            end
         end
      end else begin
         if (hit_found_ff) begin
            valid_in[hit_idx_ff] = 1'b0;
            status_in            = STATUS_INVAL;
            slot_idx_in          = hit_idx_ff;
         end
      end
   end

   // Slot memories: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.update && sector_we) sector_mem[wr_idx] <= sector_ff;
      if (cmd.update && stamp_we) stamp_mem[wr_idx] <= clock_in;
      if (cmd.issue) begin
         rd_sector_ff <= sector_mem[scan_idx_ff];
         rd_stamp_ff  <= stamp_mem[scan_idx_ff];
      end
   end

   // Request latch and result payload.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff   <= req_func;
         sector_ff <= req_sector_number;
         fail_ff   <= req_fill_failed;
      end
      if (cmd.issue) eval_idx_ff <= scan_idx_ff;
      if (cmd.update) begin
         status_ff   <= status_in;
         slot_idx_ff <= SLOT_IDX_W'(slot_idx_in);
         evicted_ff  <= evicted_in;
      end
   end

   // Scan control, trackers, valid bits and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         hit_found_ff <= 1'b0;
         hit_idx_ff   <= '0;
         inv_found_ff <= 1'b0;
         inv_idx_ff   <= '0;
         min_stamp_ff <= '0;
         min_idx_ff   <= '0;
         valid_ff     <= '0;
         clock_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else begin
         pend_ff <= cmd.issue;
         if (cmd.start) begin
            scan_idx_ff  <= '0;
            hit_found_ff <= 1'b0;
            inv_found_ff <= 1'b0;
         end else if (cmd.issue) begin
            scan_idx_ff <= scan_idx_ff + IW'(1);
         end
         // Evaluate the slot read in the previous cycle.
         if (pend_ff) begin
            if (!hit_found_ff && eval_vld && (rd_sector_ff == sector_ff)) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= eval_idx_ff;
            end
            if (!inv_found_ff && !eval_vld) begin
               inv_found_ff <= 1'b1;
               inv_idx_ff   <= eval_idx_ff;
            end
            if ((eval_idx_ff == '0) || (rd_stamp_ff < min_stamp_ff)) begin
               min_stamp_ff <= rd_stamp_ff;
               min_idx_ff   <= eval_idx_ff;
            end
         end
         if (cmd.update) begin
            valid_ff     <= valid_in;
            clock_ff     <= clock_in;
            hit_cnt_ff   <= hit_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            evict_cnt_ff <= evict_cnt_in;
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_slot_index     = slot_idx_ff;
   assign rsp_evicted        = evicted_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule
`default_nettype wire

FILE: rtl/lru_block_cache_tag_engine_unit.sv
// Top level of the LRU tag and replacement engine of a fully associative sector cache.
//
// Request channel (req_*): one word per lookup, func selects a read lookup with
// fill on miss or an invalidate; fill_failed says the backing store read for a
// miss failed. Result channel (rsp_*): one word per request with status, slot
// index, eviction flag and the running hit, miss and eviction totals.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A request is taken only while no other request is in flight. Each request
// scans all NUM_SLOTS slots through the tag and stamp memories, one slot per
// cycle; after the scan the engine drains the last read, commits the update
// and then raises rsp_valid, and the result is taken when rsp_stall is low.
// The next request can be taken in the cycle after the result is taken.
// While the receiver stalls, the result word holds and req_stall stays high.
// Synchronous reset clears all valid bits, the access clock and the counters
// at once; the block takes a request in the first cycle after reset.
`default_nettype none
module lru_block_cache_tag_engine_unit #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_func,
   input  wire logic [63:0]                        req_sector_number,
   input  wire logic                               req_fill_failed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [2:0]                              rsp_status,
   output logic [lbcte_pkg::SLOT_IDX_W-1:0]        rsp_slot_index,
   output logic                                    rsp_evicted,
   output logic [63:0]                             rsp_hit_total,
   output logic [63:0]                             rsp_miss_total,
   output logic [63:0]                             rsp_eviction_total
);
   import lbcte_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencer.
   lbcte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tag storage, trackers and counters.
   lbcte_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_sector_number  (req_sector_number),
      .req_fill_failed    (req_fill_failed),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_evicted        (rsp_evicted),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

   // A pending result blocks new requests.
   a_resp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // A result never shows in the cycle after a request is taken.
   a_no_instant_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result appeared without a scan");

   // Only a miss can report an eviction.
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |->
         (rsp_status == STATUS_FILLED || rsp_status == STATUS_FILL_FAIL))
      else $error("eviction flagged on a hit or invalidate");

   // Hit and miss totals do not move just after a result is delivered.
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> ($stable(rsp_hit_total) && $stable(rsp_miss_total)))
      else $error("totals changed outside an update");

endmodule
`default_nettype wire
